// ===== sv/lvlmtr_pkg.sv =====
`default_nettype none
package lvlmtr_pkg;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 17;
  localparam int GAIN_W   = 17;
  localparam int HOLD_W   = 5;

  // sample full scale (q1.15) and q16 shift
  localparam int SAMPLE_FULL = 32768;
  localparam int Q16_SHIFT   = 16;

  // default sizes
  localparam int WINDOW_MAX_DEF    = 64;
  localparam int HISTORY_DEPTH_DEF = 5;

  // q1.16 constants, truncated
  localparam logic [LEVEL_W-1:0] Q16_ONE      = 17'd65536;
  localparam logic [GAIN_W-1:0]  K_DECAY      = 17'd62259;
  localparam logic [GAIN_W-1:0]  K_PEAK_DECAY = 17'd58982;
  localparam logic [GAIN_W-1:0]  K_KEEP       = 17'd55705;
  localparam logic [GAIN_W-1:0]  K_NEW        = 17'd9830;
  localparam logic [HOLD_W-1:0]  HOLD_TICKS   = 5'd30;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN_MUL,
    ST_INST_CHK,
    ST_INST_DIV,
    ST_PUSH,
    ST_HIST_SUM,
    ST_AVG_DIV,
    ST_SMOOTH,
    ST_FALL_MUL,
    ST_FALL_ADD,
    ST_PEAK,
    ST_DECAY_MUL,
    ST_DECAY_SET,
    ST_PEAK_DECAY,
    ST_DONE
  } lvlmtr_state_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

// ===== sv/lvlmtr_div.sv =====
`default_nettype none
module lvlmtr_div
  import lvlmtr_pkg::*;
#(
  parameter int NUM_W = 26,
  parameter int DEN_W = 7,
  parameter int Q_W   = LEVEL_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [Q_W-1:0]        quot
);

  localparam int CNT_W = $clog2(Q_W + 1);

  // caller guarantees num < den * 2**Q_W, so the high part fits the remainder
  logic [DEN_W-1:0] rem_r;
  logic [Q_W-1:0]   ql_r;    // dividend bits out at the top, quotient bits in at the bottom
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           ge;

  assign trial = {rem_r, ql_r[Q_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(Q_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DEN_W'(num >> Q_W);
      ql_r  <= num[Q_W-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      ql_r  <= {ql_r[Q_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = ql_r;

endmodule
`default_nettype wire

// ===== sv/level_meter_peak_hold_top.sv =====
// sample word: accepted one per cycle back to back while no tick is in flight, no result
// playing tick: result set by two passes of the shared 17-step divider; a clamped window
//   skips the first pass, an empty one also skips the gain multiply; idle tick: runs on
//   the shared multiplier
// input stalls from a tick's accept until its result is loaded, one tick in flight at a time
// synchronous active-low reset clears level, peak, hold, window and fill, gain to unity
`default_nettype none
module level_meter_peak_hold_top
  import lvlmtr_pkg::*;
#(
  parameter int WINDOW_MAX    = WINDOW_MAX_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // configuration write
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic        [GAIN_W-1:0]   cfg_volume_gain,
  // input words
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_op,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  input  wire logic                       in_playing,
  // result words
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic             [LEVEL_W-1:0]  out_level,
  output logic             [LEVEL_W-1:0]  out_peak,
  output logic             [HOLD_W-1:0]   out_hold_left
);

  // window sum holds up to WINDOW_MAX full-scale magnitudes
  localparam int SUM_W  = $clog2(WINDOW_MAX * SAMPLE_FULL + 1);
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int HIDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int ACC_W  = LEVEL_W + FILL_W;
  // shared multiplier operand and product widths
  localparam int MA_W   = max_int(SUM_W, LEVEL_W);
  localparam int PROD_W = MA_W + GAIN_W;
  // (sum*gain*3) >> 15 width
  localparam int NI_W   = PROD_W + 2 - 15;
  localparam int NUM_W  = max_int(NI_W, ACC_W);
  localparam int DEN_W  = max_int(CNT_W, FILL_W);

  lvlmtr_state_t state_r, state_nxt;

  // configuration and persistent state
  logic [GAIN_W-1:0]  gain_r;
  logic [SUM_W-1:0]   win_sum_r;
  logic [CNT_W-1:0]   win_cnt_r;
  logic [FILL_W-1:0]  fill_r;
  logic [LEVEL_W-1:0] level_r;
  logic [LEVEL_W-1:0] peak_r;
  logic [HOLD_W-1:0]  hold_r;
  logic               out_valid_r;

  // working registers
  logic [LEVEL_W-1:0] hist_r [HISTORY_DEPTH];
  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]  keep_r;
  logic [LEVEL_W-1:0] inst_r;
  logic [LEVEL_W-1:0] avg_r;
  logic [ACC_W-1:0]   acc_r;
  logic [FILL_W-1:0]  idx_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic [LEVEL_W-1:0] out_peak_r;
  logic [HOLD_W-1:0]  out_hold_r;

  // shared multiplier and divider controls
  logic              mul_en;
  logic [MA_W-1:0]   mul_a;
  logic [GAIN_W-1:0] mul_b;
  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_done;
  logic [LEVEL_W-1:0] div_quot;

  // datapath helpers
  logic [LEVEL_W-1:0] sext;
  logic [LEVEL_W-1:0] mag;
  logic [PROD_W+1:0]  p3;
  logic [NI_W-1:0]    n_full;
  logic               inst_clamp;
  logic [PROD_W:0]    fall_sum;
  logic               accept;
  logic               tick_accept;
  logic               out_load;
  logic               sum_last;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign tick_accept = accept && in_op;

  // magnitude of a two's complement sample; most negative maps to full scale
  assign sext = {in_sample[SAMPLE_W-1], in_sample};
  assign mag  = in_sample[SAMPLE_W-1] ? (LEVEL_W'(0) - sext) : sext;

  // instant numerator: sum*gain*3 scaled down by the q15 sample fraction
  assign p3     = (PROD_W+2)'(prod_r) + ((PROD_W+2)'(prod_r) << 1);
  assign n_full = p3[PROD_W+1:15];
  // quotient would reach 2**17 or more, so it clamps without dividing
  assign inst_clamp = ((n_full >> LEVEL_W) >= NI_W'(win_cnt_r));

  assign fall_sum = (PROD_W+1)'(keep_r) + (PROD_W+1)'(prod_r);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign sum_last = (idx_r == fill_r);

  lvlmtr_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .Q_W   (LEVEL_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (tick_accept) begin
          if (!in_playing)              state_nxt = ST_DECAY_MUL;
          else if (win_cnt_r == '0)     state_nxt = ST_PUSH;    // empty window
          else                          state_nxt = ST_GAIN_MUL;
        end
      end
      ST_GAIN_MUL:   state_nxt = ST_INST_CHK;
      ST_INST_CHK:   state_nxt = inst_clamp ? ST_PUSH : ST_INST_DIV;
      ST_INST_DIV:   if (div_done) state_nxt = ST_PUSH;
      ST_PUSH:       state_nxt = ST_HIST_SUM;
      ST_HIST_SUM:   if (sum_last) state_nxt = ST_AVG_DIV;
      ST_AVG_DIV:    if (div_done) state_nxt = ST_SMOOTH;
      ST_SMOOTH:     state_nxt = (avg_r > level_r) ? ST_PEAK : ST_FALL_MUL;
      ST_FALL_MUL:   state_nxt = ST_FALL_ADD;
      ST_FALL_ADD:   state_nxt = ST_PEAK;
      ST_PEAK:       state_nxt = ST_DONE;
      ST_DECAY_MUL:  state_nxt = ST_DECAY_SET;
      ST_DECAY_SET:  state_nxt = (hold_r == HOLD_W'(1)) ? ST_PEAK_DECAY : ST_DONE;
      ST_PEAK_DECAY: state_nxt = ST_DONE;
      ST_DONE:       if (out_load) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs: operand steering for the shared multiplier and divider
  always_comb begin
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_r)
      ST_GAIN_MUL: begin
        mul_en = 1'b1;
        mul_a  = MA_W'(win_sum_r);
        mul_b  = gain_r;
      end
      ST_INST_CHK: begin
        if (!inst_clamp) begin
          div_start = 1'b1;
          div_num   = NUM_W'(n_full);
          div_den   = DEN_W'(win_cnt_r);
        end
      end
      ST_HIST_SUM: begin
        if (sum_last) begin
          div_start = 1'b1;
          div_num   = NUM_W'(acc_r);
          div_den   = DEN_W'(fill_r);
        end
      end
      ST_SMOOTH: begin
        if (!(avg_r > level_r)) begin
          mul_en = 1'b1;
          mul_a  = MA_W'(level_r);
          mul_b  = K_KEEP;
        end
      end
      ST_FALL_MUL: begin
        mul_en = 1'b1;
        mul_a  = MA_W'(avg_r);
        mul_b  = K_NEW;
      end
      ST_DECAY_MUL: begin
        mul_en = 1'b1;
        mul_a  = MA_W'(level_r);
        mul_b  = K_DECAY;
      end
      ST_DECAY_SET: begin
        // hold expires on this tick, scale the peak next
        if (hold_r == HOLD_W'(1)) begin
          mul_en = 1'b1;
          mul_a  = MA_W'(peak_r);
          mul_b  = K_PEAK_DECAY;
        end
      end
      default: ;
    endcase
  end

  // control and persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gain_r      <= Q16_ONE;
      win_sum_r   <= '0;
      win_cnt_r   <= '0;
      fill_r      <= '0;
      level_r     <= '0;
      peak_r      <= '0;
      hold_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        gain_r <= cfg_volume_gain;
      end
      // result word raised from the final state, dropped once taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          // samples past the window limit are dropped
          if (accept && !in_op && (win_cnt_r < CNT_W'(WINDOW_MAX))) begin
            win_sum_r <= win_sum_r + SUM_W'(mag);
            win_cnt_r <= win_cnt_r + 1'b1;
          end
        end
        ST_PUSH: begin
          if (fill_r < FILL_W'(HISTORY_DEPTH)) begin
            fill_r <= fill_r + 1'b1;
          end
        end
        ST_SMOOTH: begin
          // rising level follows the average at once
          if (avg_r > level_r) begin
            level_r <= avg_r;
          end
        end
        ST_FALL_ADD: begin
          level_r <= fall_sum[Q16_SHIFT+LEVEL_W-1:Q16_SHIFT];
        end
        ST_PEAK: begin
          if (level_r > peak_r) begin
            peak_r <= level_r;
            hold_r <= HOLD_TICKS;
          end
        end
        ST_DECAY_SET: begin
          level_r <= prod_r[Q16_SHIFT+LEVEL_W-1:Q16_SHIFT];
          if (hold_r != '0) begin
            hold_r <= hold_r - 1'b1;
          end
        end
        ST_PEAK_DECAY: begin
          peak_r <= prod_r[Q16_SHIFT+LEVEL_W-1:Q16_SHIFT];
        end
        ST_DONE: begin
          if (out_load) begin
            win_sum_r   <= '0;
            win_cnt_r   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    case (state_r)
      ST_IDLE: begin
        if (tick_accept) begin
          inst_r <= '0;
        end
      end
      ST_INST_CHK: begin
        if (inst_clamp) begin
          inst_r <= Q16_ONE;
        end
      end
      ST_INST_DIV: begin
        if (div_done) begin
          inst_r <= (div_quot > Q16_ONE) ? Q16_ONE : div_quot;
        end
      end
      ST_PUSH: begin
        // append while filling, else shift out the oldest entry
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
          if (fill_r < FILL_W'(HISTORY_DEPTH)) begin
            if (fill_r == FILL_W'(i)) begin
              hist_r[i] <= inst_r;
            end
          end else if (i == HISTORY_DEPTH - 1) begin
            hist_r[i] <= inst_r;
          end else begin
            hist_r[i] <= hist_r[(i < HISTORY_DEPTH - 1) ? i + 1 : i];
          end
        end
        acc_r <= '0;
        idx_r <= '0;
      end
      ST_HIST_SUM: begin
        if (!sum_last) begin
          acc_r <= acc_r + ACC_W'(hist_r[idx_r[HIDX_W-1:0]]);
          idx_r <= idx_r + 1'b1;
        end
      end
      ST_AVG_DIV: begin
        if (div_done) begin
          avg_r <= div_quot;
        end
      end
      ST_FALL_MUL: begin
        keep_r <= prod_r;
      end
      ST_DONE: begin
        if (out_load) begin
          out_level_r <= level_r;
          out_peak_r  <= peak_r;
          out_hold_r  <= hold_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_level     = out_level_r;
  assign out_peak      = out_peak_r;
  assign out_hold_left = out_hold_r;

  // meter values never pass full scale
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (level_r <= Q16_ONE) && (peak_r <= Q16_ONE))
    else $error("level or peak above full scale");

  // window never counts past its limit
  a_window_limit: assert property (@(posedge clk) disable iff (!rst_n)
    win_cnt_r <= CNT_W'(WINDOW_MAX))
    else $error("window count past limit");

  // divider answers only while the sequencer waits on it
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_INST_DIV || state_r == ST_AVG_DIV))
    else $error("divider done outside a wait state");

  // a tick blocks further words until its result is out
  a_tick_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    tick_accept |=> in_stall)
    else $error("word accepted while a tick is in flight");

  // a new result comes only from the final state
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == ST_DONE))
    else $error("result raised outside the final state");

endmodule
`default_nettype wire
